[sv/isrp_pkg.sv]
// Package for the interval-split random permuter.
// Shared constants and the divider control struct; no dependencies.
package isrp_pkg;
   localparam int INDEX_BITS_DEF    = 12;
   localparam int MAX_INTERVALS_DEF = 2048;
   localparam int RAND_BITS         = 31;
   localparam int CSR_INDEX_BITS    = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_INDEX = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_INDEX = 1'b1;

   localparam logic MODE_DRAW    = 1'b0;
   localparam logic MODE_RESTART = 1'b1;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;
endpackage

[sv/isrp_if.sv]
// Channel interfaces for the permuter: request, response, config write.
// Depends on isrp_pkg for field widths.
interface isrp_req_if;
   logic                           valid;
   logic                           ready;
   logic                           mode;
   logic [isrp_pkg::RAND_BITS-1:0] rand_piece;
   logic [isrp_pkg::RAND_BITS-1:0] rand_offset;
   modport source (output valid, mode, rand_piece, rand_offset, input ready);
   modport sink   (input valid, mode, rand_piece, rand_offset, output ready);
endinterface

interface isrp_rsp_if #(parameter int INDEX_BITS = isrp_pkg::INDEX_BITS_DEF);
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] drawn_index;
   logic                  exhausted;
   modport source (output valid, drawn_index, exhausted, input ready);
   modport sink   (input valid, drawn_index, exhausted, output ready);
endinterface

interface isrp_csr_if #(parameter int INDEX_BITS = isrp_pkg::INDEX_BITS_DEF);
   logic                                valid;
   logic                                ready;
   logic [isrp_pkg::CSR_INDEX_BITS-1:0] index;
   logic [INDEX_BITS-1:0]               data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[sv/interval_split_random_permuter_unit.sv]
// Interval-split random permuter: deals out min..max once each, in random order.
// Request beat: mode (0 draw, 1 restart), rand_piece, rand_offset.
// Response beat: drawn_index, exhausted (one per request).
// Config beats write min_index (index 0) or max_index (index 1); the user must send them only while idle (unchecked).
// Free intervals live in two RAMs with registered read (low, high); count in flops.
// Restart: S_APP1 writes the single interval, then S_OUT raises the response (S_OUT alone when min > max).
// Draw on empty table: straight to S_OUT, response with exhausted set.
// Draw: a 31-step remainder pass selects the entry, which is read from the RAMs
// (S_RD, S_RDW); a second 31-step pass picks the offset when it holds several values;
// compaction (S_SHRD, S_SHWR per entry) moves the entries above it down (erase keeps
// order); each remaining part of the interval is appended (S_APP1, S_APP2) while the
// table has room. The serial remainder unit and the compaction loop through the RAM
// read port set the rate.
// One item is worked at a time; a new request is taken once the result is
// in the output register and has been handed on or is being taken, so the
// next beat can be taken in the same cycle as the response is taken.
// Reset empties the table (count zero) and loads min=0, max=1; RAM
// contents stay as they are; no beat is taken while reset is high.
// A stalled receiver holds the response register; the block waits with it.
module interval_split_random_permuter_unit #(
   parameter int INDEX_BITS    = isrp_pkg::INDEX_BITS_DEF,
   parameter int MAX_INTERVALS = isrp_pkg::MAX_INTERVALS_DEF
) (
   input  logic clock,
   input  logic reset,
   isrp_req_if.sink   req,
   isrp_rsp_if.source rsp,
   isrp_csr_if.sink   csr
);
   localparam int AW = $clog2(MAX_INTERVALS);
   localparam int CW = $clog2(MAX_INTERVALS + 1);
   localparam int DW = (CW > INDEX_BITS + 1) ? CW : INDEX_BITS + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV1, S_RD, S_RDW, S_DIV2, S_SHRD, S_SHWR, S_APP1, S_APP2, S_OUT
   } state_type;

   state_type             state_ff;
   logic [INDEX_BITS-1:0] min_ff, max_ff;
   logic [CW-1:0]         count_ff;
   logic [AW-1:0]         k_ff;
   logic [INDEX_BITS-1:0] lo_ff, hi_ff, val_ff;
   logic [isrp_pkg::RAND_BITS-1:0] roff_ff, rpiece_ff;
   logic                  rsp_valid_ff, rsp_exh_ff;
   logic [INDEX_BITS-1:0] rsp_idx_ff;

   // divider
   logic                           div_start;
   logic [isrp_pkg::RAND_BITS-1:0] div_dividend;
   logic [DW-1:0]                  div_divisor;
   isrp_pkg::div_ctl_type          div_ctl;
   logic [DW-1:0]                  div_rem;

   // RAMs
   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [INDEX_BITS-1:0] wr_lo, wr_hi, rd_lo, rd_hi;

   logic idle_free;
   assign idle_free = !reset && (state_ff == S_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign req.ready = idle_free;
   assign csr.ready = !reset;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.drawn_index = rsp_idx_ff;
   assign rsp.exhausted   = rsp_exh_ff;

   isrp_div #(.DW(DW)) u_div (
      .clock, .reset,
      .start(div_start), .dividend(div_dividend), .divisor(div_divisor),
      .ctl(div_ctl), .remainder(div_rem)
   );

   isrp_ram #(.WIDTH(INDEX_BITS), .DEPTH(MAX_INTERVALS)) u_low (
      .clock, .wr_en, .wr_addr, .wr_data(wr_lo), .rd_addr, .rd_data(rd_lo)
   );
   isrp_ram #(.WIDTH(INDEX_BITS), .DEPTH(MAX_INTERVALS)) u_high (
      .clock, .wr_en, .wr_addr, .wr_data(wr_hi), .rd_addr, .rd_data(rd_hi)
   );

   logic span_gt1;
   assign span_gt1 = hi_ff > lo_ff;

   // next entry index for compaction read; count_ff already decremented
   logic [CW-1:0] k_ext;
   assign k_ext = CW'(k_ff);

   always_comb begin
      div_start    = 1'b0;
      div_dividend = rpiece_ff;
      div_divisor  = DW'(count_ff);
      wr_en        = 1'b0;
      wr_addr      = k_ff;
      wr_lo        = rd_lo;
      wr_hi        = rd_hi;
      rd_addr      = k_ff;
      unique case (state_ff)
         S_RD:   rd_addr = k_ff;
         S_DIV2: begin
            div_dividend = roff_ff;
            div_divisor  = DW'(hi_ff - lo_ff) + DW'(1);
         end
         S_SHRD: rd_addr = AW'(k_ext + CW'(1));
         S_SHWR: wr_en = 1'b1;
         S_APP1: begin
            wr_en   = 1'b1;
            wr_addr = AW'(count_ff);
            wr_lo   = val_ff + INDEX_BITS'(1);
            wr_hi   = hi_ff;
         end
         S_APP2: begin
            wr_en   = 1'b1;
            wr_addr = AW'(count_ff);
            wr_lo   = lo_ff;
            wr_hi   = val_ff - INDEX_BITS'(1);
         end
         default: ;
      endcase
      // launch pulses
      if (state_ff == S_IDLE && idle_free && req.valid && req.mode == isrp_pkg::MODE_DRAW
          && count_ff != '0 && count_ff <= CW'(MAX_INTERVALS)) begin
         div_start    = 1'b1;
         div_dividend = req.rand_piece;
      end
      if (state_ff == S_RDW && rd_hi > rd_lo) begin
         div_start    = 1'b1;
         div_dividend = roff_ff;
         div_divisor  = DW'(rd_hi - rd_lo) + DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         min_ff       <= '0;
         max_ff       <= INDEX_BITS'(1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            unique case (csr.index)
               isrp_pkg::CSR_MIN_INDEX: min_ff <= csr.data;
               isrp_pkg::CSR_MAX_INDEX: max_ff <= csr.data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (idle_free && req.valid) begin
                  roff_ff   <= req.rand_offset;
                  rpiece_ff <= req.rand_piece;
                  if (req.mode == isrp_pkg::MODE_RESTART) begin
                     rsp_idx_ff <= '0;
                     rsp_exh_ff <= 1'b0;
                     if (min_ff <= max_ff) begin
                        // single interval reload via the append path
                        count_ff <= '0;
                        lo_ff    <= min_ff - INDEX_BITS'(1);
                        hi_ff    <= max_ff;
                        val_ff   <= min_ff - INDEX_BITS'(1);
                        state_ff <= S_APP1;
                     end else begin
                        count_ff <= '0;
                        state_ff <= S_OUT;
                     end
                  end else if (count_ff == '0 || count_ff > CW'(MAX_INTERVALS)) begin
                     count_ff   <= '0;
                     rsp_idx_ff <= '0;
                     rsp_exh_ff <= 1'b1;
                     state_ff   <= S_OUT;
                  end else begin
                     state_ff <= S_DIV1;
                  end
               end
            end
            S_DIV1: if (div_ctl.done) begin
               k_ff     <= AW'(div_rem);
               state_ff <= S_RD;
            end
            S_RD: state_ff <= S_RDW;
            S_RDW: begin
               lo_ff    <= rd_lo;
               hi_ff    <= rd_hi;
               val_ff   <= rd_lo;
               count_ff <= count_ff - CW'(1);
               state_ff <= (rd_hi > rd_lo) ? S_DIV2 : S_SHRD;
            end
            S_DIV2: if (div_ctl.done) begin
               val_ff   <= lo_ff + INDEX_BITS'(div_rem);
               state_ff <= S_SHRD;
            end
            S_SHRD: begin
               if (k_ext >= count_ff) begin
                  rsp_idx_ff <= val_ff;
                  rsp_exh_ff <= 1'b0;
                  if (span_gt1 && val_ff < hi_ff && count_ff < CW'(MAX_INTERVALS))
                     state_ff <= S_APP1;
                  else if (span_gt1 && val_ff > lo_ff && count_ff < CW'(MAX_INTERVALS))
                     state_ff <= S_APP2;
                  else
                     state_ff <= S_OUT;
               end else begin
                  state_ff <= S_SHWR;
               end
            end
            S_SHWR: begin
               k_ff     <= AW'(k_ext + CW'(1));
               state_ff <= S_SHRD;
            end
            S_APP1: begin
               count_ff <= count_ff + CW'(1);
               if (span_gt1 && val_ff > lo_ff && count_ff + CW'(1) < CW'(MAX_INTERVALS))
                  state_ff <= S_APP2;
               else
                  state_ff <= S_OUT;
            end
            S_APP2: begin
               count_ff <= count_ff + CW'(1);
               state_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[sv/isrp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module isrp_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

[sv/isrp_div.sv]
// Restoring bit-serial remainder unit: 31-bit dividend mod DW-bit divisor.
// Depends on isrp_pkg.
module isrp_div #(
   parameter int DW = 13
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [isrp_pkg::RAND_BITS-1:0] dividend,
   input  logic [DW-1:0]                  divisor,
   output isrp_pkg::div_ctl_type          ctl,
   output logic [DW-1:0]                  remainder
);
   localparam int NB = isrp_pkg::RAND_BITS;
   localparam int CW = $clog2(NB + 1);

   logic [NB-1:0] quo_ff;
   logic [DW:0]   rem_ff;
   logic [DW-1:0] dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, done_ff;
   logic [DW:0]   shifted, diff;

   assign shifted = {rem_ff[DW-1:0], quo_ff[NB-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NB);
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[NB-2:0], 1'b0};
            rem_ff <= diff[DW] ? shifted : diff;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
   assign remainder = rem_ff[DW-1:0];
endmodule
